// ===== hw/rtl/qsdp_pkg.sv =====
// Package for the QR segment data packer: types, widths, codes and the
// alphanumeric character table. Used by every other file of the block.
// No dependencies.
package qsdp_pkg;

  localparam int CHAR_W     = 8;
  localparam int BITS_W     = 11;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 13;
  localparam int PART_W     = 10;
  localparam int PEND_W     = 2;
  localparam int SYM_W      = 6;
  localparam int MODE_W     = 2;
  localparam int CNT_MAX    = (2 ** CNT_W) - 1;
  localparam int MAX_CHARS_DEF = 8191;
  localparam int FIFO_DEPTH = 2;

  // Segment mode register codes; any other code packs as bytes.
  localparam logic [MODE_W-1:0] MODE_NUMERIC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALNUM   = 2'd1;

  // Group lengths in bits.
  localparam logic [LEN_W-1:0] LEN_NONE   = 4'd0;
  localparam logic [LEN_W-1:0] LEN_NUM3   = 4'd10;
  localparam logic [LEN_W-1:0] LEN_ALNUM2 = 4'd11;
  localparam logic [LEN_W-1:0] LEN_ALNUM1 = 4'd6;
  localparam logic [LEN_W-1:0] LEN_BYTE   = 4'd8;

  localparam logic [PEND_W-1:0] NUM_GROUP   = 2'd3;
  localparam logic [PEND_W-1:0] ALNUM_GROUP = 2'd2;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ALNUM,
    KIND_BYTE
  } kind_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [SYM_W-1:0]  sym;
    logic              sym_ok;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             ok;
  } lookup_t;

  function automatic lookup_t digit_lookup(input logic [CHAR_W-1:0] c);
    lookup_t r;
    r.ok  = (c >= 8'd48) && (c <= 8'd57);
    r.sym = r.ok ? SYM_W'(c - 8'd48) : '0;
    return r;
  endfunction

  // Alphanumeric table: digits, upper case letters and nine symbols.
  function automatic lookup_t alnum_lookup(input logic [CHAR_W-1:0] c);
    lookup_t r;
    r.ok  = 1'b1;
    r.sym = '0;
    priority if ((c >= 8'd48) && (c <= 8'd57)) begin
      r.sym = SYM_W'(c - 8'd48);
    end else if ((c >= 8'd65) && (c <= 8'd90)) begin
      r.sym = SYM_W'(c - 8'd55);
    end else if (c == 8'd32) begin
      r.sym = 6'd36;
    end else if (c == 8'd36) begin
      r.sym = 6'd37;
    end else if (c == 8'd37) begin
      r.sym = 6'd38;
    end else if (c == 8'd42) begin
      r.sym = 6'd39;
    end else if (c == 8'd43) begin
      r.sym = 6'd40;
    end else if (c == 8'd45) begin
      r.sym = 6'd41;
    end else if (c == 8'd46) begin
      r.sym = 6'd42;
    end else if (c == 8'd47) begin
      r.sym = 6'd43;
    end else if (c == 8'd58) begin
      r.sym = 6'd44;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qsdp_ifs.sv =====
// Channel interfaces of the QR segment data packer: input characters,
// packed results and the mode write channel. Depends on qsdp_pkg.
interface qsdp_in_if;
  logic                          valid;
  logic                          ready;
  logic [qsdp_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface qsdp_out_if;
  logic                          valid;
  logic                          ready;
  logic [qsdp_pkg::BITS_W-1:0]   group_bits;
  logic [qsdp_pkg::LEN_W-1:0]    group_len;
  logic                          bad_char;
  logic                          segment_end;
  logic [qsdp_pkg::CNT_W-1:0]    char_count;
  modport source (output valid, group_bits, group_len, bad_char, segment_end, char_count,
                  input ready);
  modport sink   (input valid, group_bits, group_len, bad_char, segment_end, char_count,
                  output ready);
endinterface

interface qsdp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qsdp_pkg::MODE_W-1:0]   segment_mode;
  modport source (output valid, segment_mode, input ready);
  modport sink   (input valid, segment_mode, output ready);
endinterface

// ===== hw/rtl/qsdp_front.sv =====
// Front end: holds the segment mode register, accepts characters and
// classifies each one into a queue entry. Depends on qsdp_pkg.
module qsdp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [qsdp_pkg::MODE_W-1:0]   cfg_mode,
  input  logic                          in_valid,
  input  logic [qsdp_pkg::CHAR_W-1:0]   in_char,
  input  logic                          in_last,
  input  logic                          q_full,
  output logic                          in_ready,
  output logic                          q_push,
  output qsdp_pkg::entry_t              q_entry
);

  logic [qsdp_pkg::MODE_W-1:0] mode_r;
  qsdp_pkg::lookup_t           dig;
  qsdp_pkg::lookup_t           aln;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qsdp_pkg::MODE_NUMERIC;
    end else if (cfg_valid) begin
      mode_r <= cfg_mode;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    dig = qsdp_pkg::digit_lookup(in_char);
    aln = qsdp_pkg::alnum_lookup(in_char);
    q_entry.char_code = in_char;
    q_entry.last      = in_last;
    unique case (mode_r)
      qsdp_pkg::MODE_NUMERIC: begin
        q_entry.kind   = qsdp_pkg::KIND_NUM;
        q_entry.sym    = dig.sym;
        q_entry.sym_ok = dig.ok;
      end
      qsdp_pkg::MODE_ALNUM: begin
        q_entry.kind   = qsdp_pkg::KIND_ALNUM;
        q_entry.sym    = aln.sym;
        q_entry.sym_ok = aln.ok;
      end
      default: begin
        q_entry.kind   = qsdp_pkg::KIND_BYTE;
        q_entry.sym    = '0;
        q_entry.sym_ok = 1'b1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/qsdp_fifo.sv =====
// Short queue between front and back, so that each side stalls on its own.
// Depends on qsdp_pkg.
module qsdp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qsdp_pkg::entry_t  wr_entry,
  input  logic              pop,
  output qsdp_pkg::entry_t  rd_entry,
  output logic              full,
  output logic              empty
);

  localparam int Depth = qsdp_pkg::FIFO_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  qsdp_pkg::entry_t  mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CntW'(Depth));
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ===== hw/rtl/qsdp_back.sv =====
// Back end: packs classified characters into groups, keeps the segment
// state and drives the result register. Depends on qsdp_pkg.
module qsdp_back #(
  parameter int MAX_CHARS = qsdp_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clr,
  input  qsdp_pkg::entry_t              q_entry,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qsdp_pkg::BITS_W-1:0]   out_bits,
  output logic [qsdp_pkg::LEN_W-1:0]    out_len,
  output logic                          out_bad,
  output logic                          out_end,
  output logic [qsdp_pkg::CNT_W-1:0]    out_count
);

  localparam int LimitInt = (MAX_CHARS > qsdp_pkg::CNT_MAX) ? qsdp_pkg::CNT_MAX : MAX_CHARS;
  localparam logic [qsdp_pkg::CNT_W-1:0] Limit = qsdp_pkg::CNT_W'(LimitInt);
  localparam int AccW = 16;

  logic [qsdp_pkg::PART_W-1:0] part_r, part_nxt;
  logic [qsdp_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic [qsdp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        err_r, err_nxt;
  logic                        ov_r, ov_nxt;
  logic                        load;
  logic [qsdp_pkg::BITS_W-1:0] bits_r, bits_nxt;
  logic [qsdp_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                        bad_r, end_r;
  logic [qsdp_pkg::CNT_W-1:0]  count_r;
  logic [AccW-1:0]             acc10, acc45;
  logic [qsdp_pkg::BITS_W-1:0] acc;
  logic [qsdp_pkg::PEND_W-1:0] pend_inc;
  logic                        emit;

  assign q_pop = !q_empty && (!ov_r || out_ready);

  assign acc10 = AccW'(part_r) * AccW'(10) + AccW'(q_entry.sym);
  assign acc45 = AccW'(part_r) * AccW'(45) + AccW'(q_entry.sym);
  assign pend_inc = pend_r + 1'b1;

  always_comb begin
    part_nxt = part_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    ov_nxt   = ov_r && !out_ready;
    bits_nxt = '0;
    len_nxt  = qsdp_pkg::LEN_NONE;
    emit     = 1'b0;
    load     = 1'b0;
    acc      = '0;
    if (q_pop) begin
      if (cnt_r < Limit) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      unique case (q_entry.kind)
        qsdp_pkg::KIND_NUM: begin
          acc = qsdp_pkg::BITS_W'(acc10);
          if (q_entry.sym_ok) begin
            if (pend_inc == qsdp_pkg::NUM_GROUP) begin
              bits_nxt = acc;
              len_nxt  = qsdp_pkg::LEN_NUM3;
              emit     = 1'b1;
              part_nxt = '0;
              pend_nxt = '0;
            end else begin
              part_nxt = qsdp_pkg::PART_W'(acc);
              pend_nxt = pend_inc;
            end
          end else begin
            err_nxt = 1'b1;
          end
          if (q_entry.last && (pend_nxt != '0)) begin
            bits_nxt = qsdp_pkg::BITS_W'(part_nxt);
            len_nxt  = qsdp_pkg::LEN_W'({pend_nxt, 1'b0}) + qsdp_pkg::LEN_W'(pend_nxt) + 1'b1;
            emit     = 1'b1;
          end
        end
        qsdp_pkg::KIND_ALNUM: begin
          acc = qsdp_pkg::BITS_W'(acc45);
          if (q_entry.sym_ok) begin
            if (pend_inc == qsdp_pkg::ALNUM_GROUP) begin
              bits_nxt = acc;
              len_nxt  = qsdp_pkg::LEN_ALNUM2;
              emit     = 1'b1;
              part_nxt = '0;
              pend_nxt = '0;
            end else begin
              part_nxt = qsdp_pkg::PART_W'(acc);
              pend_nxt = pend_inc;
            end
          end else begin
            err_nxt = 1'b1;
          end
          if (q_entry.last && (pend_nxt != '0)) begin
            bits_nxt = qsdp_pkg::BITS_W'(part_nxt);
            len_nxt  = qsdp_pkg::LEN_ALNUM1;
            emit     = 1'b1;
          end
        end
        default: begin
          bits_nxt = qsdp_pkg::BITS_W'(q_entry.char_code);
          len_nxt  = qsdp_pkg::LEN_BYTE;
          emit     = 1'b1;
        end
      endcase
      load = emit || q_entry.last;
      if (load) begin
        ov_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      err_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else if (clr) begin
      part_r <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      err_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      // The final character returns the whole segment state to zero.
      if (q_pop && q_entry.last) begin
        part_r <= '0;
        pend_r <= '0;
        cnt_r  <= '0;
        err_r  <= 1'b0;
      end else begin
        part_r <= part_nxt;
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bits_r  <= bits_nxt;
      len_r   <= len_nxt;
      bad_r   <= err_nxt;
      end_r   <= q_entry.last;
      count_r <= cnt_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_bits  = bits_r;
  assign out_len   = len_r;
  assign out_bad   = bad_r;
  assign out_end   = end_r;
  assign out_count = count_r;

endmodule

// ===== hw/rtl/qr_segment_data_packer_unit.sv =====
// QR segment data packer, top level: the front end, the queue and the back
// end. Depends on qsdp_pkg, the channel interfaces, qsdp_front/fifo/back.
//
// Usage: each request on in_if carries one character (or data byte) and
// last_char, which closes the segment. The mode register, written through
// cfg_if (always ready), selects numeric, alphanumeric or byte packing; a
// write clears the segment in progress; the user makes it only while the
// block is idle, and the block itself does not enforce this. Each completed
// group, and every final character, gives one request on out_if with the
// group value, its length, the sticky bad_char flag, segment_end and the
// saturating character count. A character accepted on in_if is written into
// the queue; the back end pops it and registers its result for out_if.
// Throughput: one character per cycle while out_if does not stall; the back
// end does one multiply-add per character, combinationally.
// When out_if stalls, the result register holds and the two-entry queue
// fills; in_if.ready drops only once the queue is full.
// Reset clears the mode to numeric and the whole segment state.
module qr_segment_data_packer_unit #(
  parameter int MAX_CHARS = qsdp_pkg::MAX_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  qsdp_in_if.sink        in_if,
  qsdp_out_if.source     out_if,
  qsdp_cfg_if.sink       cfg_if
);

  qsdp_pkg::entry_t wr_entry;
  qsdp_pkg::entry_t rd_entry;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             cfg_wr;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;

  qsdp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_wr),
    .cfg_mode  (cfg_if.segment_mode),
    .in_valid  (in_if.valid),
    .in_char   (in_if.char_code),
    .in_last   (in_if.last_char),
    .q_full    (q_full),
    .in_ready  (in_if.ready),
    .q_push    (q_push),
    .q_entry   (wr_entry)
  );

  qsdp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  qsdp_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr),
    .q_entry   (rd_entry),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_bits  (out_if.group_bits),
    .out_len   (out_if.group_len),
    .out_bad   (out_if.bad_char),
    .out_end   (out_if.segment_end),
    .out_count (out_if.char_count)
  );

endmodule

// ===== hw/rtl/qsdp_checker.sv =====
// Port checker for the QR segment data packer, bound to the top level.
// Depends on qsdp_pkg and qr_segment_data_packer_unit.
module qsdp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [qsdp_pkg::BITS_W-1:0]   group_bits,
  input logic [qsdp_pkg::LEN_W-1:0]    group_len,
  input logic                          bad_char,
  input logic                          segment_end,
  input logic [qsdp_pkg::CNT_W-1:0]    char_count
);

  // A result without bits only ever closes a segment.
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (group_len == qsdp_pkg::LEN_NONE)) |-> (segment_end && (group_bits == '0)))
    else $error("empty group on a result that does not end the segment");

  // Group values fit the capacity of their length.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((group_len != 4'd4 || group_bits < 11'd10) &&
                   (group_len != 4'd7 || group_bits < 11'd100) &&
                   (group_len != 4'd10 || group_bits < 11'd1000) &&
                   (group_len != 4'd6 || group_bits < 11'd45) &&
                   (group_len != 4'd11 || group_bits < 11'd2025) &&
                   (group_len != 4'd8 || group_bits < 11'd256)))
    else $error("group value exceeds its length");

  // Every result counts at least the character that caused it.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (char_count != '0))
    else $error("result with zero character count");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(group_bits) && $stable(group_len) &&
                                   $stable(bad_char) && $stable(segment_end) &&
                                   $stable(char_count)))
    else $error("stalled result changed");

endmodule

bind qr_segment_data_packer_unit qsdp_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .group_bits  (out_if.group_bits),
  .group_len   (out_if.group_len),
  .bad_char    (out_if.bad_char),
  .segment_end (out_if.segment_end),
  .char_count  (out_if.char_count)
);
